/* rtl/core/sba_pkg.sv */
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types, register map and constants of the selection boundary unit.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int DEFAULT_MAX_WIDTH  = 4096;
  localparam int DEFAULT_MAX_HEIGHT = 4096;

  // register map of the configuration port
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int PHASE_W     = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_VIEW_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VIEW_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DASH_PHASE  = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RESET_VIEW_WIDTH  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] RESET_VIEW_HEIGHT = 13'd480;
  localparam logic [PHASE_W-1:0]    RESET_DASH_PHASE  = 3'd0;

  localparam logic [7:0]         INSIDE_LEVEL = 8'd128;
  localparam logic [PHASE_W-1:0] DASH_HALF    = 3'd4;

  // pixel color codes
  localparam logic [1:0] COLOR_CLEAR = 2'd0;
  localparam logic [1:0] COLOR_BLACK = 2'd1;
  localparam logic [1:0] COLOR_WHITE = 2'd2;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] coverage_sample;
  } sample_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [1:0]  pixel_color;
    logic        last_of_run;
  } result_t;

  // one line store entry: row two above and row above
  typedef struct packed {
    logic older;
    logic recent;
  } row_bits_t;

  // push request into the result queue
  typedef struct packed {
    logic [1:0] count;
  } push_t;

  function automatic logic [1:0] dash_color(logic [PHASE_W-1:0] pos);
    return (pos < DASH_HALF) ? COLOR_BLACK : COLOR_WHITE;
  endfunction

endpackage

/* rtl/core/sba_stream_if.sv */
// ----------------------------------------------------------------------------
// sba_stream_if
// Valid/ready stream channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface sba_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

/* rtl/core/sba_line_store.sv */
// ----------------------------------------------------------------------------
// sba_line_store
// Two-row bit store: one write port, two registered read ports with bypass.
// ----------------------------------------------------------------------------
module sba_line_store #(
  parameter int DEPTH  = sba_pkg::DEFAULT_MAX_WIDTH,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [ADDR_W-1:0]     wr_addr_i,
  input  sba_pkg::row_bits_t    wr_data_i,
  input  logic [ADDR_W-1:0]     rd_addr_a_i,
  input  logic [ADDR_W-1:0]     rd_addr_b_i,
  output sba_pkg::row_bits_t    rd_data_a_o,
  output sba_pkg::row_bits_t    rd_data_b_o
);

  sba_pkg::row_bits_t mem [DEPTH];
  sba_pkg::row_bits_t rd_a_q;
  sba_pkg::row_bits_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // bypass the write of this cycle so the read sees the new entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (rd_addr_a_i == wr_addr_i)) begin
      rd_a_q <= wr_data_i;
    end else begin
      rd_a_q <= mem[rd_addr_a_i];
    end
    if (wr_en_i && (rd_addr_b_i == wr_addr_i)) begin
      rd_b_q <= wr_data_i;
    end else begin
      rd_b_q <= mem[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

/* rtl/core/sba_result_queue.sv */
// ----------------------------------------------------------------------------
// sba_result_queue
// Small result queue: takes up to two results a cycle, delivers one.
// ----------------------------------------------------------------------------
module sba_result_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sba_pkg::push_t       push_i,
  input  sba_pkg::result_t     item_a_i,
  input  sba_pkg::result_t     item_b_i,
  output logic                 space_o,
  sba_stream_if.source         out_o
);

  localparam int PW = sba_pkg::QUEUE_PTR_W;
  localparam int CW = sba_pkg::QUEUE_CNT_W;

  sba_pkg::result_t slots_q [sba_pkg::QUEUE_DEPTH];

  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign pop = out_o.valid && out_o.ready;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(push_i.count);
    rd_ptr_d = rd_ptr_q + PW'(pop);
    cnt_d    = cnt_q + CW'(push_i.count) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      slots_q[wr_ptr_q] <= item_a_i;
    end
    if (push_i.count == 2'd2) begin
      slots_q[wr_ptr_q + PW'(1)] <= item_b_i;
    end
  end

  // leave room for a full two-result request
  assign space_o       = (cnt_q <= CW'(sba_pkg::QUEUE_DEPTH - 2));
  assign out_o.valid   = (cnt_q != '0);
  assign out_o.payload = slots_q[rd_ptr_q];

endmodule

/* rtl/core/selection_boundary_ants_unit.sv */
// ----------------------------------------------------------------------------
// selection_boundary_ants_unit
// Marching-ants outline of a selection mask over a raster-ordered view.
// ----------------------------------------------------------------------------
// Takes one coverage sample a clock in raster order and returns, one row late,
// a color for each view pixel: black or white dash on the outline of the
// selected area, transparent elsewhere. Each pixel of the last row is also
// returned right after its own sample, so a sample there gives two results
// and that row is paced by the one-result-a-clock output; all other rows run
// at one sample a clock while the output keeps up. The two rows above are
// kept in a line store with one write port and two read ports; the entries
// for the next column are read every clock, so a sample never waits on the
// store. Row zero of a view taller than one row gives no result. Results wait
// in a four-entry queue, and a sample is taken while the queue has room for
// two. Configure only while no request is in flight.
// ----------------------------------------------------------------------------
module selection_boundary_ants_unit #(
  parameter int MAX_WIDTH  = sba_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = sba_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  sba_stream_if.sink                        sample_i,
  sba_stream_if.source                      result_o,
  input  logic                              cfg_we_i,
  input  logic [sba_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [sba_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int DW = sba_pkg::CFG_DATA_W;
  localparam int PW = sba_pkg::PHASE_W;

  function automatic logic [WW-1:0] clamp_width(logic [DW-1:0] v);
    if (v == '0) begin
      return WW'(1);
    end else if (32'(v) > MAX_WIDTH) begin
      return WW'(MAX_WIDTH);
    end
    return WW'(v);
  endfunction

  function automatic logic [HW-1:0] clamp_height(logic [DW-1:0] v);
    if (v == '0) begin
      return HW'(1);
    end else if (32'(v) > MAX_HEIGHT) begin
      return HW'(MAX_HEIGHT);
    end
    return HW'(v);
  endfunction

  // configuration
  logic [DW-1:0] view_width_q, view_width_d;
  logic [DW-1:0] view_height_q, view_height_d;
  logic [PW-1:0] dash_phase_q, dash_phase_d;

  always_comb begin
    view_width_d  = view_width_q;
    view_height_d = view_height_q;
    dash_phase_d  = dash_phase_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        sba_pkg::REG_VIEW_WIDTH:  view_width_d  = cfg_data_i;
        sba_pkg::REG_VIEW_HEIGHT: view_height_d = cfg_data_i;
        sba_pkg::REG_DASH_PHASE:  dash_phase_d  = cfg_data_i[PW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_width_q  <= sba_pkg::RESET_VIEW_WIDTH;
      view_height_q <= sba_pkg::RESET_VIEW_HEIGHT;
      dash_phase_q  <= sba_pkg::RESET_DASH_PHASE;
    end else begin
      view_width_q  <= view_width_d;
      view_height_q <= view_height_d;
      dash_phase_q  <= dash_phase_d;
    end
  end

  // position
  logic [XW-1:0] col_q, col_d;
  logic [YW-1:0] row_q, row_d;
  logic [WW-1:0] w_cur, w_nxt;
  logic [HW-1:0] h_cur;
  logic [XW-1:0] x;
  logic [YW-1:0] y;
  logic          x_last, y_last;
  logic          accept;
  logic          cur;
  logic          queue_space;

  assign accept = sample_i.valid && sample_i.ready;
  assign cur    = (sample_i.payload.coverage_sample >= sba_pkg::INSIDE_LEVEL);

  always_comb begin
    w_cur  = clamp_width(view_width_q);
    h_cur  = clamp_height(view_height_q);
    w_nxt  = clamp_width(view_width_d);
    // restart a counter left beyond a shrunken size
    x      = (32'(col_q) >= 32'(w_cur)) ? '0 : col_q;
    y      = (32'(row_q) >= 32'(h_cur)) ? '0 : row_q;
    x_last = (32'(x) + 1 >= 32'(w_cur));
    y_last = (32'(y) + 1 >= 32'(h_cur));
    col_d  = col_q;
    row_d  = row_q;
    if (accept) begin
      if (x_last) begin
        col_d = '0;
        row_d = y_last ? '0 : y + YW'(1);
      end else begin
        col_d = x + XW'(1);
        row_d = y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line store: fetch the entries of the next column every cycle
  logic [XW-1:0]      rd_addr_a, rd_addr_b;
  sba_pkg::row_bits_t rd_a, rd_b;
  sba_pkg::row_bits_t wr_data;
  logic               left_q;

  always_comb begin
    rd_addr_a      = (32'(col_d) >= 32'(w_nxt)) ? '0 : col_d;
    rd_addr_b      = (32'(rd_addr_a) + 1 >= MAX_WIDTH) ? '0 : rd_addr_a + XW'(1);
    wr_data.older  = rd_a.recent;
    wr_data.recent = cur;
  end

  sba_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (XW)
  ) u_line_store (
    .clk_i       (clk_i),
    .wr_en_i     (accept),
    .wr_addr_i   (x),
    .wr_data_i   (wr_data),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b)
  );

  // hold the row above at the previous column as left neighbor
  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_q <= rd_a.recent;
    end
  end

  // classify
  logic             has_above;
  logic             border;
  logic             edge_px;
  logic [PW-1:0]    pos_above, pos_here;
  sba_pkg::result_t res_above, res_here;
  sba_pkg::result_t item_a, item_b;
  sba_pkg::push_t   push;

  always_comb begin
    has_above = (y != '0);
    border    = (x == '0) || (y == YW'(1)) || x_last;
    edge_px   = rd_a.recent &&
                (border || !left_q || !rd_b.recent || !rd_a.older || !cur);
    pos_above = PW'(x) + (PW'(y) - PW'(1)) + dash_phase_q;
    pos_here  = PW'(x) + PW'(y) + dash_phase_q;

    res_above.pixel_x     = 12'(x);
    res_above.pixel_y     = 12'(y - YW'(1));
    res_above.pixel_color = edge_px ? sba_pkg::dash_color(pos_above) : sba_pkg::COLOR_CLEAR;
    res_above.last_of_run = !y_last;

    // last row: every inside pixel sits on the border
    res_here.pixel_x     = 12'(x);
    res_here.pixel_y     = 12'(y);
    res_here.pixel_color = cur ? sba_pkg::dash_color(pos_here) : sba_pkg::COLOR_CLEAR;
    res_here.last_of_run = 1'b1;

    item_a     = has_above ? res_above : res_here;
    item_b     = res_here;
    push.count = accept ? (2'(has_above) + 2'(y_last)) : 2'd0;
  end

  sba_result_queue u_result_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_a_i (item_a),
    .item_b_i (item_b),
    .space_o  (queue_space),
    .out_o    (result_o)
  );

  assign sample_i.ready = queue_space;

endmodule
